@@ design/cosr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosr_pkg
// Shared widths, defaults, controller states and the beat carried along the
// sorting row of the constrained-order regrouper.
// ----------------------------------------------------------------------------
package cosr_pkg;

  localparam int LAYER_W        = 5;
  localparam int GROUP_W        = 5;
  localparam int POS_W          = 5;
  localparam int MAX_LAYERS_DEF = 32;

  // Input beat kinds
  localparam logic KIND_TABLE = 1'b0;
  localparam logic KIND_ORDER = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT,
    ST_SETTLE,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

  // One entry travelling through or held in a sorting cell; seq is the
  // entry's position in the stored order and breaks ties between equal groups
  typedef struct packed {
    logic               vld;
    logic [GROUP_W-1:0] key;
    logic [POS_W-1:0]   seq;
    logic [LAYER_W-1:0] layer;
  } cell_beat_t;

  // Row-wide control
  typedef struct packed {
    logic pop;
  } cell_ctrl_t;

endpackage

@@ design/cosr_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosr_cell
// One cell of the insertion-sort row: holds the smaller of its entry and the
// incoming beat, hands the other on to the next cell, or shifts towards the
// head on a pop.
// ----------------------------------------------------------------------------
module cosr_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cosr_pkg::cell_ctrl_t ctrl,
  input  cosr_pkg::cell_beat_t in_beat,
  input  cosr_pkg::cell_beat_t right_hold,
  output cosr_pkg::cell_beat_t pass_beat,
  output cosr_pkg::cell_beat_t hold_beat
);

  cosr_pkg::cell_beat_t hold_r, hold_nxt;
  cosr_pkg::cell_beat_t pass_r, pass_nxt;

  // Keep the smaller of group then order position, so equal groups keep
  // their original order even when a displaced entry moves down the row
  always_comb begin
    hold_nxt     = hold_r;
    pass_nxt     = in_beat;
    pass_nxt.vld = 1'b0;
    if (ctrl.pop) begin
      hold_nxt = right_hold;
    end else if (in_beat.vld) begin
      if (!hold_r.vld) begin
        hold_nxt = in_beat;
      end else if ({in_beat.key, in_beat.seq} < {hold_r.key, hold_r.seq}) begin
        hold_nxt = in_beat;
        pass_nxt = hold_r;
      end else begin
        pass_nxt = in_beat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r.vld <= 1'b0;
      pass_r.vld <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
      pass_r <= pass_nxt;
    end
  end

  assign pass_beat = pass_r;
  assign hold_beat = hold_r;

endmodule

@@ design/cosr_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosr_chain
// Row of sorting cells. Beats enter at the head and ripple one cell per
// cycle; once settled the head holds the smallest group and a pop shifts the
// whole row one cell towards the head.
// ----------------------------------------------------------------------------
module cosr_chain #(
  parameter int MAX_LAYERS = cosr_pkg::MAX_LAYERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cosr_pkg::cell_ctrl_t ctrl,
  input  cosr_pkg::cell_beat_t ins_beat,
  output cosr_pkg::cell_beat_t head_beat
);

  cosr_pkg::cell_beat_t pass_w [MAX_LAYERS];
  cosr_pkg::cell_beat_t hold_w [MAX_LAYERS];

  genvar k;
  generate
    for (k = 0; k < MAX_LAYERS; k++) begin : g_cell
      cosr_pkg::cell_beat_t left_w;
      cosr_pkg::cell_beat_t right_w;

      // Wire each cell to its neighbours; past the tail the row is empty
      if (k == 0) begin : g_head
        assign left_w = ins_beat;
      end else begin : g_mid
        assign left_w = pass_w[k-1];
      end
      if (k == MAX_LAYERS - 1) begin : g_tail
        assign right_w = '0;
      end else begin : g_body
        assign right_w = hold_w[k+1];
      end

      cosr_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .in_beat    (left_w),
        .right_hold (right_w),
        .pass_beat  (pass_w[k]),
        .hold_beat  (hold_w[k])
      );
    end
  endgenerate

  assign head_beat = hold_w[0];

endmodule

@@ design/constrained_order_stable_regroup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// constrained_order_stable_regroup
// Loads a group table and a layer order, then re-emits the order with the
// constrained layers stably sorted by group into the constrained positions.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------
//   input    | in_valid/in_ready  | in_kind, in_layer_id, in_group,
//            |                    | in_constrained, in_is_last
//   result   | out_valid/out_ready| out_position, out_layer, out_last_out
//
// Table and order beats load at one per cycle. The order beat marked last
// starts a regroup of n stored elements: they stream through the order
// buffer and table reads into the cell row, the row is left to settle, then
// each result passes an order buffer read and the output register. A
// stalled result holds the emitter; no input beat is taken until the
// sequence is out.
// Reset marks every table entry unconstrained through per-entry flags; there
// is no clearing pass.
// ----------------------------------------------------------------------------
module constrained_order_stable_regroup #(
  parameter int MAX_LAYERS = cosr_pkg::MAX_LAYERS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic [cosr_pkg::LAYER_W-1:0] in_layer_id,
  input  logic [cosr_pkg::GROUP_W-1:0] in_group,
  input  logic                         in_constrained,
  input  logic                         in_is_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cosr_pkg::POS_W-1:0]   out_position,
  output logic [cosr_pkg::LAYER_W-1:0] out_layer,
  output logic                         out_last_out
);

  localparam int IDX_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int CNT_W = $clog2(MAX_LAYERS + 1);
  localparam int SET_W = $clog2(MAX_LAYERS + 5);
  localparam int CMP_W = cosr_pkg::LAYER_W + 1;

  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_LAYERS);
  localparam logic [SET_W-1:0] SET_LAST = SET_W'(MAX_LAYERS + 3);
  localparam logic [CMP_W-1:0] LYR_LIM  = CMP_W'(MAX_LAYERS);

  cosr_pkg::state_t state_r, state_nxt;

  // Storage
  logic [cosr_pkg::GROUP_W-1:0] grp_mem [MAX_LAYERS];
  logic [cosr_pkg::LAYER_W-1:0] ob_mem  [MAX_LAYERS];
  logic [MAX_LAYERS-1:0]        con_r;
  logic [MAX_LAYERS-1:0]        conpos_r;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] sort_idx_r;
  logic [CNT_W-1:0] pos_r;
  logic [SET_W-1:0] set_cnt_r;

  // Lookup pipeline
  logic                         s1_vld_r, s2_vld_r;
  logic [IDX_W-1:0]             s1_idx_r, s2_idx_r;
  logic [cosr_pkg::LAYER_W-1:0] ob_q_r;
  logic [cosr_pkg::LAYER_W-1:0] s2_layer_r;
  logic [cosr_pkg::GROUP_W-1:0] grp_q_r;
  logic                         con_q_r;

  // Result register
  logic                         out_vld_r;
  logic [cosr_pkg::POS_W-1:0]   out_pos_r;
  logic [cosr_pkg::LAYER_W-1:0] out_layer_r;
  logic                         out_last_r;

  logic                 in_acc;
  logic                 tbl_wr_ok;
  logic                 ord_wr_ok;
  logic                 sort_issue;
  logic                 emit_load;
  logic                 emit_last;
  logic                 emit_con;
  logic                 q_in_rng;
  logic [IDX_W-1:0]     q_idx;
  logic [IDX_W-1:0]     ob_raddr;
  logic [CNT_W-1:0]     pos_inc;
  cosr_pkg::cell_ctrl_t row_ctrl;
  cosr_pkg::cell_beat_t ins_beat;
  cosr_pkg::cell_beat_t head_beat;

  assign in_ready   = (state_r == cosr_pkg::ST_LOAD);
  assign in_acc     = in_valid && in_ready;
  assign tbl_wr_ok  = in_acc && (in_kind == cosr_pkg::KIND_TABLE) &&
                      ({1'b0, in_layer_id} < LYR_LIM);
  assign ord_wr_ok  = in_acc && (in_kind == cosr_pkg::KIND_ORDER) && (count_r < CNT_MAX);
  assign sort_issue = (state_r == cosr_pkg::ST_SORT) && (sort_idx_r < count_r);

  assign pos_inc   = pos_r + 1'b1;
  assign emit_last = (pos_inc == count_r);
  assign emit_con  = conpos_r[pos_r[IDX_W-1:0]];
  assign emit_load = (state_r == cosr_pkg::ST_EMIT_OUT) && (!out_vld_r || out_ready);

  // Next state and row control
  always_comb begin
    state_nxt    = state_r;
    row_ctrl.pop = 1'b0;
    case (state_r)
      cosr_pkg::ST_LOAD: begin
        if (in_acc && (in_kind == cosr_pkg::KIND_ORDER) && in_is_last) begin
          state_nxt = cosr_pkg::ST_SORT;
        end
      end
      cosr_pkg::ST_SORT: begin
        if (!sort_issue) begin
          state_nxt = cosr_pkg::ST_SETTLE;
        end
      end
      cosr_pkg::ST_SETTLE: begin
        if (set_cnt_r == SET_LAST) begin
          state_nxt = cosr_pkg::ST_EMIT_RD;
        end
      end
      cosr_pkg::ST_EMIT_RD: begin
        state_nxt = cosr_pkg::ST_EMIT_OUT;
      end
      cosr_pkg::ST_EMIT_OUT: begin
        if (emit_load) begin
          row_ctrl.pop = emit_con;
          state_nxt    = emit_last ? cosr_pkg::ST_LOAD : cosr_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = cosr_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cosr_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Group table: constrained flags reset, groups written on table beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      con_r <= '0;
    end else if (tbl_wr_ok) begin
      con_r[in_layer_id[IDX_W-1:0]] <= in_constrained;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_wr_ok) begin
      grp_mem[in_layer_id[IDX_W-1:0]] <= in_group;
    end
  end

  // Order buffer: append order beats until full, read one address per cycle
  assign ob_raddr = (state_r == cosr_pkg::ST_SORT) ? sort_idx_r[IDX_W-1:0]
                                                   : pos_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (ord_wr_ok) begin
      ob_mem[count_r[IDX_W-1:0]] <= in_layer_id;
    end
    ob_q_r <= ob_mem[ob_raddr];
  end

  // Element count, sort issue index, settle timer, emit position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      sort_idx_r <= '0;
      set_cnt_r  <= '0;
      pos_r      <= '0;
    end else begin
      if (ord_wr_ok) begin
        count_r <= count_r + 1'b1;
      end else if (emit_load && emit_last) begin
        count_r <= '0;
      end
      if (state_r == cosr_pkg::ST_LOAD) begin
        sort_idx_r <= '0;
      end else if (sort_issue) begin
        sort_idx_r <= sort_idx_r + 1'b1;
      end
      if (state_r == cosr_pkg::ST_SETTLE) begin
        set_cnt_r <= set_cnt_r + 1'b1;
      end else begin
        set_cnt_r <= '0;
      end
      if (state_r == cosr_pkg::ST_SETTLE) begin
        pos_r <= '0;
      end else if (emit_load) begin
        pos_r <= pos_inc;
      end
    end
  end

  // Look up each stored layer's group; out-of-range layers are unconstrained
  assign q_in_rng = ({1'b0, ob_q_r} < LYR_LIM);
  assign q_idx    = q_in_rng ? ob_q_r[IDX_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= sort_issue;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r   <= sort_idx_r[IDX_W-1:0];
    s2_idx_r   <= s1_idx_r;
    s2_layer_r <= ob_q_r;
    grp_q_r    <= grp_mem[q_idx];
    con_q_r    <= q_in_rng && con_r[q_idx];
    if (s2_vld_r) begin
      conpos_r[s2_idx_r] <= con_q_r;
    end
  end

  // Feed constrained layers into the sorting row, tagged with their position
  always_comb begin
    ins_beat.vld   = s2_vld_r && con_q_r;
    ins_beat.key   = grp_q_r;
    ins_beat.seq   = cosr_pkg::POS_W'(s2_idx_r);
    ins_beat.layer = s2_layer_r;
  end

  cosr_chain #(
    .MAX_LAYERS (MAX_LAYERS)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (row_ctrl),
    .ins_beat  (ins_beat),
    .head_beat (head_beat)
  );

  // Result register: constrained positions take the head of the row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_pos_r   <= cosr_pkg::POS_W'(pos_r);
      out_layer_r <= emit_con ? head_beat.layer : ob_q_r;
      out_last_r  <= emit_last;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_position = out_pos_r;
  assign out_layer    = out_layer_r;
  assign out_last_out = out_last_r;

endmodule

@@ tb/cosr_regroup_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosr_regroup_checker
// Watches both channels of the regrouper. Keeps its own copy of the group
// table and the pending order, works out the regrouped sequence when the
// closing order beat is taken, and compares every result beat with it.
// ----------------------------------------------------------------------------
module cosr_regroup_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         in_kind,
  input  logic [cosr_pkg::LAYER_W-1:0] in_layer_id,
  input  logic [cosr_pkg::GROUP_W-1:0] in_group,
  input  logic                         in_constrained,
  input  logic                         in_is_last,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [cosr_pkg::POS_W-1:0]   out_position,
  input  logic [cosr_pkg::LAYER_W-1:0] out_layer,
  input  logic                         out_last_out,
  output int                           fail_count,
  output int                           pending,
  output int                           results_checked,
  output int                           sequences_done,
  output int                           longest_seq
);
  import cosr_pkg::*;

  localparam int DEPTH    = MAX_LAYERS_DEF;
  localparam int N_GROUPS = 1 << GROUP_W;
  // Bit GROUP_W set marks a layer with no group
  localparam logic [GROUP_W:0] FREE_ENTRY = {1'b1, {GROUP_W{1'b0}}};

  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [LAYER_W-1:0] layer;
    logic               last;
  } slot_t;

  logic [GROUP_W:0]   group_of [DEPTH];
  logic [LAYER_W-1:0] order_buf [DEPTH];
  int                 order_len;
  slot_t              regrouped_q [$];

  // Stable counting sort of the constrained layers, written back into the
  // constrained positions front to back; free layers stay where they are
  task automatic regroup_sequence();
    logic [LAYER_W-1:0] sorted [DEPTH];
    logic [LAYER_W-1:0] lay;
    int                 fill;
    int                 k;
    slot_t              s;
    fill = 0;
    for (int g = 0; g < N_GROUPS; g++) begin
      for (int i = 0; i < order_len; i++) begin
        lay = order_buf[i];
        if (!group_of[lay][GROUP_W] && group_of[lay][GROUP_W-1:0] == g) begin
          sorted[fill] = lay;
          fill++;
        end
      end
    end
    k = 0;
    for (int i = 0; i < order_len; i++) begin
      lay = order_buf[i];
      if (!group_of[lay][GROUP_W] && k < fill) begin
        lay = sorted[k];
        k++;
      end
      s.position = POS_W'(i);
      s.layer    = lay;
      s.last     = (i == order_len - 1);
      regrouped_q.insert(regrouped_q.size(), s);
    end
    sequences_done++;
    if (order_len > longest_seq) longest_seq = order_len;
    order_len = 0;
  endtask

  // Apply one accepted input beat to the shadow state
  task automatic take_beat();
    if (in_kind == KIND_TABLE) begin
      group_of[in_layer_id] = in_constrained ? {1'b0, in_group} : FREE_ENTRY;
    end else begin
      // Drop elements once the buffer is full
      if (order_len < DEPTH) begin
        order_buf[order_len] = in_layer_id;
        order_len++;
      end
      if (in_is_last) regroup_sequence();
    end
  endtask

  // Compare one result beat with the oldest expectation
  task automatic check_result();
    slot_t s;
    if (regrouped_q.size() == 0) begin
      $error("out_layer: unexpected result beat, position %0d layer %0d",
             out_position, out_layer);
      fail_count++;
    end else begin
      s = regrouped_q.pop_front();
      results_checked++;
      if (out_position !== s.position) begin
        $error("out_position: expected %0d, got %0d", s.position, out_position);
        fail_count++;
      end
      if (out_layer !== s.layer) begin
        $error("out_layer: expected %0d, got %0d (position %0d)",
               s.layer, out_layer, s.position);
        fail_count++;
      end
      if (out_last_out !== s.last) begin
        $error("out_last_out: expected %0d, got %0d (position %0d)",
               s.last, out_last_out, s.position);
        fail_count++;
      end
    end
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) group_of[i] = FREE_ENTRY;
      order_len = 0;
      regrouped_q.delete();
      pending = 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) take_beat();
      pending = regrouped_q.size();
    end
  end

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
    sequences_done  = 0;
    longest_seq     = 0;
  end

endmodule

@@ tb/constrained_order_stable_regroup_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// constrained_order_stable_regroup_tb
// Drives table writes and layer orders into the regrouper with random gaps
// and receiver stalls, including one long receiver hold-off and overfull
// orders. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module constrained_order_stable_regroup_tb;
  import cosr_pkg::*;

  localparam int TARGET_BEATS = 470;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 4 * MAX_LAYERS_DEF + 40;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_kind;
  logic [LAYER_W-1:0] in_layer_id;
  logic [GROUP_W-1:0] in_group;
  logic               in_constrained;
  logic               in_is_last;
  logic               out_valid;
  logic               out_ready;
  logic [POS_W-1:0]   out_position;
  logic [LAYER_W-1:0] out_layer;
  logic               out_last_out;

  int fail_count;
  int pending;
  int results_checked;
  int sequences_done;
  int longest_seq;

  int send_gap_pct;
  int stall_pct;
  bit hold_req;
  int holds_done;
  int beats_sent;
  int table_writes;

  constrained_order_stable_regroup dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_layer_id    (in_layer_id),
    .in_group       (in_group),
    .in_constrained (in_constrained),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_position   (out_position),
    .out_layer      (out_layer),
    .out_last_out   (out_last_out)
  );

  cosr_regroup_checker regroup_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_layer_id     (in_layer_id),
    .in_group        (in_group),
    .in_constrained  (in_constrained),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_position    (out_position),
    .out_layer       (out_layer),
    .out_last_out    (out_last_out),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .sequences_done  (sequences_done),
    .longest_seq     (longest_seq)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop for a hung run
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Offer one beat from a falling edge and hold it until taken
  task automatic send_beat(input logic kind, input logic [LAYER_W-1:0] lay,
                           input logic [GROUP_W-1:0] grp, input logic con,
                           input logic last);
    int gap;
    if ($urandom_range(0, 99) < send_gap_pct) begin
      gap = pick_gap();
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_layer_id    <= lay;
    in_group       <= grp;
    in_constrained <= con;
    in_is_last     <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    beats_sent++;
    if (kind == KIND_TABLE) table_writes++;
  endtask

  // Table write with a random group, often from a narrow range to force ties
  task automatic send_table_write();
    logic [GROUP_W-1:0] grp;
    grp = ($urandom_range(0, 1) == 0) ? GROUP_W'($urandom_range(0, 3))
                                      : GROUP_W'($urandom_range(0, 31));
    send_beat(KIND_TABLE, LAYER_W'($urandom_range(0, 31)), grp,
              ($urandom_range(0, 3) != 0), 1'($urandom_range(0, 1)));
  endtask

  // Well-formed order of len elements, with the odd table write slipped in
  task automatic send_sequence(input int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 8) send_table_write();
      send_beat(KIND_ORDER, LAYER_W'($urandom_range(0, 31)),
                GROUP_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                (i == len - 1));
    end
  endtask

  // Mix of table bursts and orders, mostly short, a few full or overfull
  task automatic random_traffic(input int upto);
    int pick;
    while (beats_sent < upto) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        repeat ($urandom_range(1, 5)) send_table_write();
      end else if (pick < 85) begin
        send_sequence($urandom_range(1, 8));
      end else if (pick < 97) begin
        send_sequence($urandom_range(9, MAX_LAYERS_DEF));
      end else begin
        send_sequence($urandom_range(MAX_LAYERS_DEF + 1, MAX_LAYERS_DEF + 4));
      end
    end
  endtask

  // Result side: random stalls, and one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk);
        holds_done++;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat (pick_gap() - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = KIND_TABLE;
    in_layer_id    = '0;
    in_group       = '0;
    in_constrained = 1'b0;
    in_is_last     = 1'b0;
    send_gap_pct   = 0;
    stall_pct      = 0;
    hold_req       = 1'b0;
    holds_done     = 0;
    beats_sent     = 0;
    table_writes   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Untouched table: every layer stays where it stands
    send_beat(KIND_ORDER, 5'd31, 5'd0, 1'b1, 1'b0);
    send_beat(KIND_ORDER, 5'd0, 5'd31, 1'b0, 1'b0);
    send_beat(KIND_ORDER, 5'd7, 5'd0, 1'b1, 1'b1);
    // Table extremes, a last flag on a table write, a write that frees a layer
    send_beat(KIND_TABLE, 5'd0, 5'd31, 1'b1, 1'b0);
    send_beat(KIND_TABLE, 5'd31, 5'd0, 1'b1, 1'b1);
    send_beat(KIND_TABLE, 5'd5, 5'd3, 1'b1, 1'b0);
    send_beat(KIND_TABLE, 5'd7, 5'd3, 1'b1, 1'b0);
    send_beat(KIND_TABLE, 5'd9, 5'd17, 1'b0, 1'b1);
    // Mixed order with a free layer, a tie in one group and a repeated layer
    send_beat(KIND_ORDER, 5'd0, 5'd0, 1'b0, 1'b0);
    send_beat(KIND_ORDER, 5'd9, 5'd0, 1'b0, 1'b0);
    send_beat(KIND_ORDER, 5'd5, 5'd0, 1'b0, 1'b0);
    send_beat(KIND_ORDER, 5'd31, 5'd0, 1'b0, 1'b0);
    send_beat(KIND_ORDER, 5'd7, 5'd0, 1'b0, 1'b0);
    send_beat(KIND_ORDER, 5'd5, 5'd0, 1'b0, 1'b1);
    // Single-element order
    send_beat(KIND_ORDER, 5'd31, 5'd0, 1'b0, 1'b1);

    send_gap_pct = 35;
    stall_pct    = 35;
    random_traffic(160);

    // Long receiver hold-off while a full order and an overfull one are offered
    send_gap_pct = 0;
    hold_req     = 1'b1;
    send_sequence(MAX_LAYERS_DEF);
    send_sequence(MAX_LAYERS_DEF + 3);

    // Stretch with no idling on either side
    stall_pct = 0;
    random_traffic(330);

    send_gap_pct = 20;
    stall_pct    = 50;
    random_traffic(TARGET_BEATS);

    // Drain
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Summary: %0d input beats (%0d table writes), %0d orders regrouped, longest %0d",
             beats_sent, table_writes, sequences_done, longest_seq);
    $display("Summary: %0d result beats compared, %0d receiver hold-off(s) of %0d cycles",
             results_checked, holds_done, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
